### rtl/core/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    localparam logic [7:0] HDR_BINARY = 8'h82;
    localparam logic [7:0] HDR_TEXT   = 8'h81;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [6:0] LEN_EXT16  = 7'd126;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DRAIN   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_HDR  = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_present;
        logic       binary_frame;
        logic       frame_done;
        status_t    frame_status;
    } result_t;

endpackage

### rtl/core/wsd_in_stage.sv
`timescale 1ns / 1ps

module wsd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_end
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       load;

    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= s_tdata;
            end_reg  <= s_tlast;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_end   = end_reg;

endmodule

### rtl/core/wsd_parser.sv
`timescale 1ns / 1ps

module wsd_parser
#(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_end,
    input  logic             room,
    output logic             take,
    output logic             res_valid,
    output wsd_pkg::result_t res
);

    import wsd_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    phase_t                 phase_reg,   phase_next;
    logic [3:0]             left_reg,    left_next;
    logic [LENGTH_BITS-1:0] decl_reg,    decl_next;
    logic [31:0]            key_reg,     key_next;
    logic                   mask_on_reg, mask_on_next;
    logic                   binary_reg,  binary_next;
    logic [LENGTH_BITS-1:0] count_reg,   count_next;
    logic                   bad_reg,     bad_next;

    logic       present;
    logic [7:0] key_byte;
    status_t    status;

    assign take     = in_valid && room;
    assign key_byte = key_reg[{~count_reg[1:0], 3'b000} +: 8];

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        decl_next    = decl_reg;
        key_next     = key_reg;
        mask_on_next = mask_on_reg;
        binary_next  = binary_reg;
        count_next   = count_reg;
        bad_next     = bad_reg;
        present      = 1'b0;

        case (phase_reg)
            PH_FIRST:
            begin
                if (in_byte == HDR_BINARY)
                begin
                    binary_next = 1'b1;
                    phase_next  = PH_SECOND;
                end
                else if (in_byte == HDR_TEXT)
                begin
                    binary_next = 1'b0;
                    phase_next  = PH_SECOND;
                end
                else
                begin
                    bad_next   = 1'b1;
                    phase_next = PH_DRAIN;
                end
            end
            PH_SECOND:
            begin
                mask_on_next = in_byte[7];
                if (in_byte[6:0] == LEN_EXT64)
                begin
                    left_next  = EXT64_BYTES;
                    phase_next = PH_EXTLEN;
                end
                else if (in_byte[6:0] == LEN_EXT16)
                begin
                    left_next  = EXT16_BYTES;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    decl_next = {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]};
                    if (in_byte[7])
                    begin
                        left_next  = KEY_BYTES;
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN:
            begin
                if (decl_reg[LENGTH_BITS-1 -: 8] != 8'd0)
                begin
                    decl_next = LEN_MAX;
                end
                else
                begin
                    decl_next = {decl_reg[LENGTH_BITS-9:0], in_byte};
                end
                left_next = left_reg - 4'd1;
                if (left_next == 4'd0)
                begin
                    if (mask_on_reg)
                    begin
                        left_next  = KEY_BYTES;
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_MASK:
            begin
                key_next  = {key_reg[23:0], in_byte};
                left_next = left_reg - 4'd1;
                if (left_next == 4'd0)
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                present = 1'b1;
                if (count_reg != LEN_MAX)
                begin
                    count_next = count_reg + LENGTH_BITS'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (bad_next)
        begin
            status = ST_BAD_HDR;
        end
        else if (phase_next == PH_PAYLOAD && count_next == decl_next)
        begin
            status = ST_OK;
        end
        else
        begin
            status = ST_MISMATCH;
        end

        res_valid        = take && (present || in_end);
        res.payload_byte = present ? (in_byte ^ (mask_on_reg ? key_byte : 8'd0)) : 8'd0;
        res.byte_present = present;
        res.binary_frame = bad_next ? 1'b0 : binary_next;
        res.frame_done   = in_end;
        res.frame_status = in_end ? status : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            left_reg    <= 4'd0;
            decl_reg    <= '0;
            key_reg     <= 32'd0;
            mask_on_reg <= 1'b0;
            binary_reg  <= 1'b0;
            count_reg   <= '0;
            bad_reg     <= 1'b0;
        end
        else if (take)
        begin
            if (in_end)
            begin
                phase_reg   <= PH_FIRST;
                left_reg    <= 4'd0;
                decl_reg    <= '0;
                key_reg     <= 32'd0;
                mask_on_reg <= 1'b0;
                binary_reg  <= 1'b0;
                count_reg   <= '0;
                bad_reg     <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                left_reg    <= left_next;
                decl_reg    <= decl_next;
                key_reg     <= key_next;
                mask_on_reg <= mask_on_next;
                binary_reg  <= binary_next;
                count_reg   <= count_next;
                bad_reg     <= bad_next;
            end
        end
    end

endmodule

### rtl/core/wsd_out_skid.sv
`timescale 1ns / 1ps

module wsd_out_skid
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wsd_pkg::result_t res,
    output logic             room,
    output logic             m_tvalid,
    input  logic             m_tready,
    output wsd_pkg::result_t m_res
);

    import wsd_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = res;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign room     = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_res    = main_reg;

endmodule

### rtl/core/websocket_frame_deframer.sv
// receives one websocket frame a byte at a time on s_axis, tlast on the final byte
// header must open with 0x82 (binary) or 0x81 (text), then 7/16/64-bit length
// and an optional 4-byte masking key
// every payload byte leaves on m_axis unmasked, tuser set for binary frames
// the final byte of each frame always yields a transfer with tlast and a status:
// ok, bad first byte or size mismatch; downstream drops frames not ok
// header bytes other than the final one yield no transfer
// m_axis_tvalid rises once the byte has passed the input register, the combinational
// parser and the result register; a stall on m_axis can hold it in between
// throughput: one byte per cycle while m_axis does not stall
// reset clears the parser to expect a new frame and empties the input and result registers
// when m_axis stalls, a two-entry result buffer absorbs the byte in flight and
// s_axis_tready drops once it and the input register are full; nothing is lost
`timescale 1ns / 1ps

module websocket_frame_deframer
#(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // payload_byte, byte_present, frame_status, zero fill
    output logic        m_axis_tuser,   // binary_frame
    output logic        m_axis_tlast
);

    import wsd_pkg::*;

    logic       take;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_end;
    logic       room;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    wsd_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .take     (take),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_end   (in_end)
    );

    wsd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_end    (in_end),
        .room      (room),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_skid u_out_skid
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .res      (res),
        .room     (room),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_res    (m_res)
    );

    assign m_axis_tdata = {5'd0, m_res.frame_status, m_res.byte_present, m_res.payload_byte};
    assign m_axis_tuser = m_res.binary_frame;
    assign m_axis_tlast = m_res.frame_done;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import wsd_pkg::*;

    localparam int LEN_BITS = LENGTH_BITS_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_FROM = 700;
    localparam int QUIET_TO = 1100;

    class deframe_scoreboard;
        phase_t phase;
        logic [3:0] ext_left;
        logic [63:0] decl_len;
        logic [63:0] pay_count;
        logic [63:0] len_lim;
        logic [31:0] mask_key;
        logic mask_on;
        logic bin_kind;
        logic hdr_bad;
        result_t expected_q[$];
        int errors;
        int n_checked;
        int n_ok;
        int n_bad_hdr;
        int n_mismatch;

        function new();
            len_lim = (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);
            errors = 0;
            n_checked = 0;
            n_ok = 0;
            n_bad_hdr = 0;
            n_mismatch = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase = PH_FIRST;
            ext_left = '0;
            decl_len = '0;
            mask_key = '0;
            mask_on = 1'b0;
            bin_kind = 1'b0;
            pay_count = '0;
            hdr_bad = 1'b0;
        endfunction

        function void after_length();
            if (mask_on)
            begin
                ext_left = KEY_BYTES;
                phase = PH_MASK;
            end
            else
            begin
                phase = PH_PAYLOAD;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t ns: %s got %0h expected %0h", $time, field, got, want);
            errors++;
        endtask

        // predicts the out transfer (if any) caused by one accepted byte
        function void note_input(logic [7:0] rx_data, logic end_flag);
            result_t r;
            logic present;
            int idx;
            r = '0;
            present = 1'b0;
            case (phase)
                PH_FIRST:
                begin
                    if (rx_data == HDR_BINARY)
                    begin
                        bin_kind = 1'b1;
                        phase = PH_SECOND;
                    end
                    else if (rx_data == HDR_TEXT)
                    begin
                        bin_kind = 1'b0;
                        phase = PH_SECOND;
                    end
                    else
                    begin
                        hdr_bad = 1'b1;
                        phase = PH_DRAIN;
                    end
                end
                PH_SECOND:
                begin
                    mask_on = rx_data[7];
                    if (rx_data[6:0] == LEN_EXT64)
                    begin
                        ext_left = EXT64_BYTES;
                        phase = PH_EXTLEN;
                    end
                    else if (rx_data[6:0] == LEN_EXT16)
                    begin
                        ext_left = EXT16_BYTES;
                        phase = PH_EXTLEN;
                    end
                    else
                    begin
                        decl_len = {57'd0, rx_data[6:0]};
                        after_length();
                    end
                end
                PH_EXTLEN:
                begin
                    if ((decl_len >> (LEN_BITS - 8)) != 64'd0)
                        decl_len = len_lim;
                    else
                        decl_len = ((decl_len << 8) | {56'd0, rx_data}) & len_lim;
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0)
                        after_length();
                end
                PH_MASK:
                begin
                    mask_key = {mask_key[23:0], rx_data};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0)
                        phase = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    idx = int'(pay_count[1:0]);
                    r.payload_byte = rx_data ^ (mask_on ? mask_key[31 - 8 * idx -: 8] : 8'h00);
                    present = 1'b1;
                    if (pay_count < len_lim)
                        pay_count = pay_count + 64'd1;
                end
                default:
                begin
                end
            endcase

            if (present || end_flag)
            begin
                r.byte_present = present;
                r.binary_frame = hdr_bad ? 1'b0 : bin_kind;
                r.frame_done = end_flag;
                if (!end_flag)
                    r.frame_status = ST_OK;
                else if (hdr_bad)
                    r.frame_status = ST_BAD_HDR;
                else if (phase == PH_PAYLOAD && pay_count == decl_len)
                    r.frame_status = ST_OK;
                else
                    r.frame_status = ST_MISMATCH;
                expected_q = {expected_q, r};
            end
            if (end_flag)
                clear_frame();
        endfunction

        task check_result(logic [15:0] data, logic user, logic lst);
            result_t e;
            if (expected_q.size() == 0)
            begin
                report_mismatch("transfer with none expected, tdata", 64'(data), '0);
                return;
            end
            e = expected_q.pop_front();
            n_checked++;
            if (data[7:0] !== e.payload_byte)
                report_mismatch("payload_byte", 64'(data[7:0]), 64'(e.payload_byte));
            if (data[8] !== e.byte_present)
                report_mismatch("byte_present", 64'(data[8]), 64'(e.byte_present));
            if (data[10:9] !== e.frame_status)
                report_mismatch("frame_status", 64'(data[10:9]), 64'(e.frame_status));
            if (data[15:11] !== 5'd0)
                report_mismatch("tdata fill", 64'(data[15:11]), '0);
            if (user !== e.binary_frame)
                report_mismatch("binary_frame", 64'(user), 64'(e.binary_frame));
            if (lst !== e.frame_done)
                report_mismatch("frame_done", 64'(lst), 64'(e.frame_done));
            if (e.frame_done)
            begin
                if (e.frame_status == ST_OK)
                    n_ok++;
                else if (e.frame_status == ST_BAD_HDR)
                    n_bad_hdr++;
                else
                    n_mismatch++;
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    deframe_scoreboard sb = new();
    logic [7:0] pkt_q[$];
    int items_sent = 0;
    int frames_sent = 0;
    bit idle_on = 1'b1;

    websocket_frame_deframer uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= (idle_on && $urandom_range(0, 99) < 21) ? 1'b0 : 1'b1;
    end

    task add_byte(input logic [7:0] b);
        pkt_q = {pkt_q, b};
    endtask

    task send_item(input logic [7:0] rx_data, input logic end_flag);
        idle_on = !(items_sent >= QUIET_FROM && items_sent < QUIET_TO);
        while (idle_on && $urandom_range(0, 99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rx_data;
        s_axis_tlast <= end_flag;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(rx_data, end_flag);
        items_sent++;
    endtask

    task send_frame();
        for (int i = 0; i < pkt_q.size(); i++)
            send_item(pkt_q[i], i == pkt_q.size() - 1);
        frames_sent++;
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // header, optional key, payload; payload length sometimes off by one to three, always short past 300
    task make_good_frame(output int hdr_len);
        logic masked;
        logic [63:0] len;
        logic [31:0] mkey;
        int lsel;
        int n;
        pkt_q.delete();
        masked = 1'($urandom_range(0, 1));
        lsel = $urandom_range(0, 9);
        add_byte($urandom_range(0, 1) ? HDR_BINARY : HDR_TEXT);
        if (lsel < 6)
        begin
            len = ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 125))
                                              : 64'($urandom_range(0, 12));
            add_byte({masked, len[6:0]});
        end
        else if (lsel < 8)
        begin
            len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 65535))
                                              : 64'($urandom_range(0, 40));
            add_byte({masked, LEN_EXT16});
            add_byte(len[15:8]);
            add_byte(len[7:0]);
        end
        else
        begin
            len = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 20));
            add_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                add_byte(len[8 * i +: 8]);
        end
        if (masked)
        begin
            mkey = $urandom;
            for (int i = 3; i >= 0; i--)
                add_byte(mkey[8 * i +: 8]);
        end
        hdr_len = pkt_q.size();
        n = (len <= 64'd300) ? int'(len) : int'($urandom_range(0, 8));
        if ($urandom_range(0, 99) < 12)
        begin
            if ($urandom_range(0, 1))
                n = n + int'($urandom_range(1, 3));
            else
                n = (n > 3) ? n - int'($urandom_range(1, 3)) : 0;
        end
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int hl;
        int pick;
        int cut;
        int dir_items;
        bit paused;
        logic [7:0] first;

        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // frame ends on its first byte
        pkt_q = '{HDR_TEXT};
        send_frame();
        // bad first byte, alone and with a tail
        pkt_q = '{8'h00};
        send_frame();
        pkt_q = '{8'h55, 8'h12, 8'hff};
        send_frame();
        // header complete on the last byte with zero length
        pkt_q = '{HDR_BINARY, 8'h00};
        send_frame();
        pkt_q = '{HDR_BINARY, {1'b0, LEN_EXT16}, 8'h00, 8'h00};
        send_frame();
        // masked text frame
        pkt_q = '{HDR_TEXT, 8'h83, 8'h11, 8'h22, 8'h44, 8'h88, 8'h00, 8'hff, 8'h5a};
        send_frame();
        // one payload byte too many
        pkt_q = '{HDR_BINARY, 8'h02, 8'hff, 8'h00, 8'haa};
        send_frame();
        drain();
        dir_items = items_sent;

        while (items_sent < dir_items + RANDOM_ITEMS)
        begin
            if (!paused && items_sent >= dir_items + RANDOM_ITEMS / 2)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                make_good_frame(hl);
            end
            else if (pick < 82)
            begin
                make_good_frame(hl);
                cut = $urandom_range(1, hl);
                while (pkt_q.size() > cut)
                    void'(pkt_q.pop_back());
            end
            else if (pick < 92)
            begin
                pkt_q.delete();
                do
                    first = 8'($urandom_range(0, 255));
                while (first == HDR_BINARY || first == HDR_TEXT);
                add_byte(first);
                cut = $urandom_range(0, 10);
                for (int i = 0; i < cut; i++)
                    add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                pkt_q.delete();
                cut = $urandom_range(1, 12);
                for (int i = 0; i < cut; i++)
                    add_byte(8'($urandom_range(0, 255)));
            end
            send_frame();
        end

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d frames, %0d bytes in, %0d transfers out checked",
                 frames_sent, items_sent, sb.n_checked);
        $display("frame endings: %0d ok, %0d bad header, %0d size mismatch",
                 sb.n_ok, sb.n_bad_hdr, sb.n_mismatch);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
